// ----- hw/rtl/fed_pkg.sv -----
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types and constants of the flight event detector: mode codes,
// register indexes, register reset values and the configuration struct.
// ----------------------------------------------------------------------------
package fed_pkg;

    // altitude window depth, range 2 to 32
    localparam int WINDOW_DEPTH = 8;
    localparam int POS_W        = $clog2(WINDOW_DEPTH);

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int MODE_W   = 2;
    localparam int LIMIT_W  = 16;
    localparam int HOLD_W   = 4;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    // hit counter saturation value
    localparam logic [HOLD_W-1:0] CNT_MAX = 4'd15;

    // check selected by the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_APOGEE  = 2'd0,
        MODE_LAND    = 2'd1,
        MODE_BURNOUT = 2'd2
    } mode_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_RISE_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_HOLD_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_STILL_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_HOLD_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURNOUT_ACCEL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURNOUT_HOLD_COUNT  = 3'd5;

    // register reset values (Q8 where fractional)
    localparam logic [LIMIT_W-1:0]         RST_APOGEE_RISE_LIMIT   = 16'd77;
    localparam logic [HOLD_W-1:0]          RST_APOGEE_HOLD_COUNT   = 4'd8;
    localparam logic [LIMIT_W-1:0]         RST_LAND_STILL_LIMIT    = 16'd26;
    localparam logic [HOLD_W-1:0]          RST_LAND_HOLD_COUNT     = 4'd4;
    localparam logic signed [SAMPLE_W-1:0] RST_BURNOUT_ACCEL_LIMIT = 24'sd2048;
    localparam logic [HOLD_W-1:0]          RST_BURNOUT_HOLD_COUNT  = 4'd3;

    // configuration seen by the detection logic
    typedef struct packed {
        logic [LIMIT_W-1:0]         apogee_rise_limit;
        logic [HOLD_W-1:0]          apogee_hold_count;
        logic [LIMIT_W-1:0]         land_still_limit;
        logic [HOLD_W-1:0]          land_hold_count;
        logic signed [SAMPLE_W-1:0] burnout_accel_limit;
        logic [HOLD_W-1:0]          burnout_hold_count;
    } cfg_t;

endpackage

// ----- hw/rtl/flight_event_detector_top.sv -----
// ----------------------------------------------------------------------------
// flight_event_detector_top
// Apogee, landing and burnout detection on a stream of Q15.8 samples.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample, tuser: mode
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: detected
//   cfg       in   cfg_wr_en                     cfg_index, cfg_wdata
//
// One sample per clock is sustained while the output is not stalled; an
// accepted sample passes the input register and then the result register.
// The whole per-sample update is combinational between those registers.
// Reset clears the counters and restores register defaults; the altitude
// window needs no clearing. A stalled output holds the pipeline in place.
// ----------------------------------------------------------------------------
module flight_event_detector_top
    import fed_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // [23:0] sample
    input  logic [1:0]           s_axis_tuser,   // [1:0] mode
    // master side
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] detected, [7:1] zero
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t                       cfg_reg;
    logic                       in_valid_reg, in_valid_next;
    logic [MODE_W-1:0]          mode_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       det_reg;
    logic                       det;
    logic                       advance;
    logic                       in_accept;

    // pipeline handshake
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready  = !in_valid_reg || advance;
        in_accept      = s_axis_tvalid && s_axis_tready;
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        m_axis_tvalid  = out_valid_reg;
        m_axis_tdata   = {7'd0, det_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result words
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg   <= s_axis_tuser;
            sample_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            det_reg <= det;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apogee_rise_limit   <= RST_APOGEE_RISE_LIMIT;
            cfg_reg.apogee_hold_count   <= RST_APOGEE_HOLD_COUNT;
            cfg_reg.land_still_limit    <= RST_LAND_STILL_LIMIT;
            cfg_reg.land_hold_count     <= RST_LAND_HOLD_COUNT;
            cfg_reg.burnout_accel_limit <= RST_BURNOUT_ACCEL_LIMIT;
            cfg_reg.burnout_hold_count  <= RST_BURNOUT_HOLD_COUNT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_APOGEE_RISE_LIMIT:   cfg_reg.apogee_rise_limit   <= cfg_wdata[LIMIT_W-1:0];
                REG_APOGEE_HOLD_COUNT:   cfg_reg.apogee_hold_count   <= cfg_wdata[HOLD_W-1:0];
                REG_LAND_STILL_LIMIT:    cfg_reg.land_still_limit    <= cfg_wdata[LIMIT_W-1:0];
                REG_LAND_HOLD_COUNT:     cfg_reg.land_hold_count     <= cfg_wdata[HOLD_W-1:0];
                REG_BURNOUT_ACCEL_LIMIT: cfg_reg.burnout_accel_limit <= cfg_wdata[SAMPLE_W-1:0];
                REG_BURNOUT_HOLD_COUNT:  cfg_reg.burnout_hold_count  <= cfg_wdata[HOLD_W-1:0];
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // detection logic and state
    fed_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .mode     (mode_reg),
        .sample   (sample_reg),
        .cfg      (cfg_reg),
        .detected (det)
    );

endmodule

// ----- hw/rtl/fed_core.sv -----
// ----------------------------------------------------------------------------
// fed_core
// Detector state (altitude window, shared hit counter, last moving altitude)
// and the combinational apogee, landing and burnout checks.
// ----------------------------------------------------------------------------
module fed_core
    import fed_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  cfg_t                       cfg,
    output logic                       detected
);

    logic signed [SAMPLE_W-1:0] window_reg [WINDOW_DEPTH];
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       full_reg, full_next;
    logic [HOLD_W-1:0]          cnt_reg, cnt_next;
    logic signed [SAMPLE_W-1:0] last_alt_reg, last_alt_next;
    logic                       win_wr;

    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SAMPLE_W:0]   rise;
    logic signed [SAMPLE_W:0]   move;
    logic [SAMPLE_W:0]          move_abs;
    logic [POS_W-1:0]           pos_inc;
    logic [HOLD_W-1:0]          cnt_sat;
    logic [HOLD_W-1:0]          apo_cnt;
    logic                       rise_small;
    logic                       alt_still;
    logic                       accel_high;

    // shared arithmetic
    always_comb
    begin
        oldest     = window_reg[pos_reg];
        rise       = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(oldest);
        move       = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(last_alt_reg);
        move_abs   = move[SAMPLE_W] ? (SAMPLE_W+1)'(-move) : (SAMPLE_W+1)'(move);
        rise_small = rise < $signed({{(SAMPLE_W+1-LIMIT_W){1'b0}}, cfg.apogee_rise_limit});
        alt_still  = move_abs < {{(SAMPLE_W+1-LIMIT_W){1'b0}}, cfg.land_still_limit};
        accel_high = sample > cfg.burnout_accel_limit;
        pos_inc    = (pos_reg == POS_W'(WINDOW_DEPTH-1)) ? '0 : pos_reg + 1'b1;
        cnt_sat    = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        apo_cnt    = rise_small ? cnt_sat : '0;
    end

    // per-mode next state and event flag
    always_comb
    begin
        pos_next      = pos_reg;
        full_next     = full_reg;
        cnt_next      = cnt_reg;
        last_alt_next = last_alt_reg;
        win_wr        = 1'b0;
        detected      = 1'b0;
        unique case (mode)
            MODE_APOGEE:
            begin
                win_wr   = 1'b1;
                pos_next = pos_inc;
                if (!full_reg)
                begin
                    // filling the window, no counting
                    if (pos_reg == POS_W'(WINDOW_DEPTH-1))
                    begin
                        full_next = 1'b1;
                    end
                end
                else if (apo_cnt >= cfg.apogee_hold_count)
                begin
                    cnt_next = '0;
                    detected = 1'b1;
                end
                else
                begin
                    cnt_next = apo_cnt;
                end
            end
            MODE_LAND:
            begin
                if (cnt_reg >= cfg.land_hold_count)
                begin
                    cnt_next = '0;
                    detected = 1'b1;
                end
                else if (alt_still)
                begin
                    cnt_next = cnt_sat;
                end
                else
                begin
                    cnt_next      = '0;
                    last_alt_next = sample;
                end
            end
            MODE_BURNOUT:
            begin
                if (cnt_reg >= cfg.burnout_hold_count)
                begin
                    cnt_next = '0;
                    detected = 1'b1;
                end
                else
                begin
                    cnt_next = accel_high ? cnt_sat : '0;
                end
            end
            default:
            begin
                // unused mode leaves the state alone
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            cnt_reg      <= '0;
            last_alt_reg <= '0;
        end
        else if (step_en)
        begin
            pos_reg      <= pos_next;
            full_reg     <= full_next;
            cnt_reg      <= cnt_next;
            last_alt_reg <= last_alt_next;
        end
    end

    // altitude window, written at the oldest entry
    always_ff @(posedge clk)
    begin
        if (step_en && win_wr)
        begin
            window_reg[pos_reg] <= sample;
        end
    end

endmodule
